// ===== sv/lcd4_pkg.sv =====
// Shared types, codes and the init step table for the 4-bit character-LCD sequencer.
// No dependencies; every design module of the block imports this package.
package lcd4_pkg;

   // Request kinds as carried in the func field
   typedef enum logic [2:0] {
      FUNC_INIT  = 3'd0,
      FUNC_CMD   = 3'd1,
      FUNC_DATA  = 3'd2,
      FUNC_CLEAR = 3'd3,
      FUNC_GOTO  = 3'd4
   } func_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_ENABLE_HIGH = 3'd0,
      CSR_ENABLE_LOW  = 3'd1,
      CSR_CMD_WAIT    = 3'd2,
      CSR_DATA_WAIT   = 3'd3,
      CSR_INIT_WAIT   = 3'd4,
      CSR_POWER_UP    = 3'd5,
      CSR_ROW1_BASE   = 3'd6
   } csr_index_type;

   // Wait added after the final nibble of a byte
   typedef enum logic [1:0] {
      POST_CMD   = 2'd0,
      POST_DATA  = 2'd1,
      POST_CLEAR = 2'd2
   } post_type;

   // Which hold time a step uses
   typedef enum logic [2:0] {
      HOLD_POWER   = 3'd0,
      HOLD_EH      = 3'd1,
      HOLD_EL      = 3'd2,
      HOLD_EL_IW   = 3'd3,
      HOLD_EL_CW   = 3'd4,
      HOLD_EL_CWIW = 3'd5,
      HOLD_EL_DW   = 3'd6
   } hold_sel_type;

   // Back-end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   localparam int unsigned HOLD_W      = 24;
   localparam int unsigned STEP_W      = 5;
   localparam logic [STEP_W-1:0] INIT_LAST = 5'd24;
   localparam logic [STEP_W-1:0] BYTE_LAST = 5'd3;

   localparam logic [7:0] BYTE_CLEAR    = 8'h01;
   localparam logic [7:0] BYTE_SET_ADDR = 8'h80;

   // Configuration register file contents
   typedef struct packed {
      logic [15:0] enable_high_ticks;
      logic [15:0] enable_low_ticks;
      logic [19:0] command_wait_ticks;
      logic [19:0] data_wait_ticks;
      logic [19:0] init_wait_ticks;
      logic [23:0] power_up_ticks;
      logic [6:0]  row1_base;
   } cfg_type;

   // One classified request, as queued between front and back
   typedef struct packed {
      logic      is_init;
      logic      rs;
      logic [7:0] value;
      post_type  post;
   } job_type;

   // One entry of the init sequence
   typedef struct packed {
      logic         en;
      logic [3:0]   nib;
      hold_sel_type hold_sel;
   } step_type;

   // Init sequence: power-up wait, nibbles 3 3 3 2, then bytes 28 0C 06 01
   function automatic step_type init_step(input logic [STEP_W-1:0] idx);
      step_type s;
      s = '{en: 1'b0, nib: 4'h0, hold_sel: HOLD_POWER};
      case (idx)
         5'd0:  s = '{1'b0, 4'h0, HOLD_POWER};
         5'd1:  s = '{1'b1, 4'h3, HOLD_EH};
         5'd2:  s = '{1'b0, 4'h3, HOLD_EL_IW};
         5'd3:  s = '{1'b1, 4'h3, HOLD_EH};
         5'd4:  s = '{1'b0, 4'h3, HOLD_EL_IW};
         5'd5:  s = '{1'b1, 4'h3, HOLD_EH};
         5'd6:  s = '{1'b0, 4'h3, HOLD_EL_IW};
         5'd7:  s = '{1'b1, 4'h2, HOLD_EH};
         5'd8:  s = '{1'b0, 4'h2, HOLD_EL_IW};
         5'd9:  s = '{1'b1, 4'h2, HOLD_EH};
         5'd10: s = '{1'b0, 4'h2, HOLD_EL};
         5'd11: s = '{1'b1, 4'h8, HOLD_EH};
         5'd12: s = '{1'b0, 4'h8, HOLD_EL_CW};
         5'd13: s = '{1'b1, 4'h0, HOLD_EH};
         5'd14: s = '{1'b0, 4'h0, HOLD_EL};
         5'd15: s = '{1'b1, 4'hC, HOLD_EH};
         5'd16: s = '{1'b0, 4'hC, HOLD_EL_CW};
         5'd17: s = '{1'b1, 4'h0, HOLD_EH};
         5'd18: s = '{1'b0, 4'h0, HOLD_EL};
         5'd19: s = '{1'b1, 4'h6, HOLD_EH};
         5'd20: s = '{1'b0, 4'h6, HOLD_EL_CW};
         5'd21: s = '{1'b1, 4'h0, HOLD_EH};
         5'd22: s = '{1'b0, 4'h0, HOLD_EL};
         5'd23: s = '{1'b1, 4'h1, HOLD_EH};
         5'd24: s = '{1'b0, 4'h1, HOLD_EL_CWIW};
         default: s = '{1'b0, 4'h0, HOLD_POWER};
      endcase
      return s;
   endfunction

endpackage

// ===== sv/lcd4_csr.sv =====
// Configuration registers of the LCD sequencer, written through the csr_ channel.
// Depends on lcd4_pkg.
module lcd4_csr
   import lcd4_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;

   // Update the addressed register, drop writes to unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ENABLE_HIGH: cfg_in.enable_high_ticks  = csr_data[15:0];
            CSR_ENABLE_LOW:  cfg_in.enable_low_ticks   = csr_data[15:0];
            CSR_CMD_WAIT:    cfg_in.command_wait_ticks = csr_data[19:0];
            CSR_DATA_WAIT:   cfg_in.data_wait_ticks    = csr_data[19:0];
            CSR_INIT_WAIT:   cfg_in.init_wait_ticks    = csr_data[19:0];
            CSR_POWER_UP:    cfg_in.power_up_ticks     = csr_data[23:0];
            CSR_ROW1_BASE:   cfg_in.row1_base          = csr_data[6:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable_high_ticks  <= 16'd500;
         cfg_ff.enable_low_ticks   <= 16'd500;
         cfg_ff.command_wait_ticks <= 20'd4000;
         cfg_ff.data_wait_ticks    <= 20'd2000;
         cfg_ff.init_wait_ticks    <= 20'd30000;
         cfg_ff.power_up_ticks     <= 24'd500000;
         cfg_ff.row1_base          <= 7'd64;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/lcd4_front.sv =====
// Front end: decodes a request into a job (RS, byte, post wait) for the queue.
// Depends on lcd4_pkg.
module lcd4_front
   import lcd4_pkg::*;
(
   input  logic       req_valid,
   input  logic [2:0] func,
   input  logic [7:0] byte_value,
   input  logic       row,
   input  logic [5:0] col,
   input  logic [6:0] row1_base,
   output logic       push,
   output job_type    job
);

   logic [7:0] row_addr;
   logic [7:0] goto_addr;

   // Build the cursor address for a goto request
   assign row_addr  = row ? {1'b0, row1_base} : 8'd0;
   assign goto_addr = (row_addr + {2'b00, col}) | BYTE_SET_ADDR;

   // Classify the request; unknown kinds are taken and dropped
   always_comb begin
      push = 1'b0;
      job  = '{is_init: 1'b0, rs: 1'b0, value: byte_value, post: POST_CMD};
      case (func)
         FUNC_INIT: begin
            push        = req_valid;
            job.is_init = 1'b1;
         end
         FUNC_CMD: begin
            push = req_valid;
         end
         FUNC_DATA: begin
            push     = req_valid;
            job.rs   = 1'b1;
            job.post = POST_DATA;
         end
         FUNC_CLEAR: begin
            push      = req_valid;
            job.value = BYTE_CLEAR;
            job.post  = POST_CLEAR;
         end
         FUNC_GOTO: begin
            push      = req_valid;
            job.value = goto_addr;
         end
         default: push = 1'b0;
      endcase
   end

endmodule

// ===== sv/lcd4_queue.sv =====
// Two-entry job queue between the request decoder and the pin sequencer.
// Depends on lcd4_pkg.
module lcd4_queue
   import lcd4_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head,
   output logic    full,
   output logic    empty
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full    = count_ff[1];
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== sv/lcd4_back.sv =====
// Back end: expands one queued job into pin steps, one step per free output slot.
// Depends on lcd4_pkg; reads the live configuration registers.
module lcd4_back
   import lcd4_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  job_type     head,
   input  logic        empty,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        reg_select,
   output logic        enable_pin,
   output logic [3:0]  nibble_pins,
   output logic [23:0] hold_ticks,
   output logic        last_step
);

   state_type         state_ff, state_in;
   job_type           job_ff, job_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              valid_ff, valid_in;
   logic              rs_ff, rs_in;
   logic              en_ff, en_in;
   logic [3:0]        nib_ff, nib_in;
   logic [23:0]       hold_ff, hold_in;
   logic              last_ff, last_in;

   logic              out_free;
   step_type          step;
   logic [STEP_W-1:0] last_idx;
   logic [23:0]       eh, el, cw, dw, iw;

   assign out_free = !valid_ff || rsp_tready;
   assign last_idx = job_ff.is_init ? INIT_LAST : BYTE_LAST;

   assign eh = {8'd0, cfg.enable_high_ticks};
   assign el = {8'd0, cfg.enable_low_ticks};
   assign cw = {4'd0, cfg.command_wait_ticks};
   assign dw = {4'd0, cfg.data_wait_ticks};
   assign iw = {4'd0, cfg.init_wait_ticks};

   // Pick the current step: init table, or high/low nibble of a byte
   always_comb begin
      if (job_ff.is_init) begin
         step = init_step(cnt_ff);
      end else begin
         step.en  = !cnt_ff[0];
         step.nib = cnt_ff[1] ? job_ff.value[3:0] : job_ff.value[7:4];
         if (cnt_ff[0] == 1'b0) begin
            step.hold_sel = HOLD_EH;
         end else if (cnt_ff[1] == 1'b0) begin
            step.hold_sel = HOLD_EL;
         end else begin
            case (job_ff.post)
               POST_DATA:  step.hold_sel = HOLD_EL_DW;
               POST_CLEAR: step.hold_sel = HOLD_EL_CWIW;
               default:    step.hold_sel = HOLD_EL_CW;
            endcase
         end
      end
   end

   // Resolve the hold time of the current step
   always_comb begin
      case (step.hold_sel)
         HOLD_POWER:   hold_in = cfg.power_up_ticks;
         HOLD_EH:      hold_in = eh;
         HOLD_EL:      hold_in = el;
         HOLD_EL_IW:   hold_in = el + iw;
         HOLD_EL_CW:   hold_in = el + cw;
         HOLD_EL_CWIW: hold_in = el + cw + iw;
         HOLD_EL_DW:   hold_in = el + dw;
         default:      hold_in = el;
      endcase
   end

   // Sequence: take a job when idle, then emit one step per free slot
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      cnt_in   = cnt_ff;
      pop      = 1'b0;
      valid_in = out_free ? 1'b0 : valid_ff;
      rs_in    = rs_ff;
      en_in    = en_ff;
      nib_in   = nib_ff;
      last_in  = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               job_in   = head;
               cnt_in   = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (out_free) begin
               valid_in = 1'b1;
               rs_in    = job_ff.rs;
               en_in    = step.en;
               nib_in   = step.nib;
               last_in  = (cnt_ff == last_idx);
               if (cnt_ff == last_idx) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + STEP_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   // Hold payload while the output slot is occupied
   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      cnt_ff  <= cnt_in;
      rs_ff   <= rs_in;
      en_ff   <= en_in;
      nib_ff  <= nib_in;
      last_ff <= last_in;
      if (state_ff == ST_RUN && out_free) begin
         hold_ff <= hold_in;
      end
   end

   assign rsp_tvalid  = valid_ff;
   assign reg_select  = rs_ff;
   assign enable_pin  = en_ff;
   assign nibble_pins = nib_ff;
   assign hold_ticks  = hold_ff;
   assign last_step   = last_ff;

endmodule

// ===== sv/char_lcd_4bit_sequencer_unit.sv =====
// Top level of the 4-bit character-LCD sequencer: request decoder, job queue,
// pin sequencer and configuration registers. Depends on lcd4_pkg and the lcd4_ modules.
//
// Each accepted request turns into a run of pin steps on the rsp_ channel: four steps
// for command, data, clear and goto requests, 25 for init, the last one marked by
// rsp_tlast; unknown request kinds are taken and produce nothing. The sequencer emits
// one step per cycle while rsp_tready stays high and passes through its idle state to
// pick up each next job from a two-entry queue. Requests are taken while the queue has
// room, so up to two requests can wait while a step sits in the output register.
// hold_ticks tells the downstream pin driver how long to keep each level; the
// sequencer does no timing of its own. Configuration is written through csr_ (always
// ready) and must only change while no request is in flight.
module char_lcd_4bit_sequencer_unit
   import lcd4_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // byte_value[7:0], row[8], col[14:9], zeros
   input  logic [2:0]  req_tuser,  // func[2:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // enable_pin[0], nibble_pins[4:1], hold_ticks[28:5], zeros
   output logic        rsp_tuser,  // reg_select[0]
   output logic        rsp_tlast,  // last_step
   // configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   cfg_type     cfg;
   job_type     front_job;
   job_type     head;
   logic        push, pop, full, empty;
   logic        enable_pin;
   logic [3:0]  nibble_pins;
   logic [23:0] hold_ticks;

   assign csr_ready  = 1'b1;
   assign req_tready = !full;

   lcd4_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lcd4_front u_front (
      .req_valid  (req_tvalid && !full),
      .func       (req_tuser),
      .byte_value (req_tdata[7:0]),
      .row        (req_tdata[8]),
      .col        (req_tdata[14:9]),
      .row1_base  (cfg.row1_base),
      .push       (push),
      .job        (front_job)
   );

   lcd4_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (front_job),
      .pop      (pop),
      .head     (head),
      .full     (full),
      .empty    (empty)
   );

   lcd4_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .head        (head),
      .empty       (empty),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .reg_select  (rsp_tuser),
      .enable_pin  (enable_pin),
      .nibble_pins (nibble_pins),
      .hold_ticks  (hold_ticks),
      .last_step   (rsp_tlast)
   );

   // Pack the result fields, lowest first
   assign rsp_tdata = {3'b000, hold_ticks, nibble_pins, enable_pin};

endmodule

// ===== sv/lcd4_checker.sv =====
// Port-level checks for the LCD sequencer, bound to the top level.
// Depends only on the top-level ports.
module lcd4_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   // No step shows right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled step holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // A request never ends on an enable-high step
   a_last_low: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> !rsp_tlast)
      else $error("request ended with enable high");

   // Enable-high steps carry only the 16-bit enable time
   a_high_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[28:21] == 8'd0)
      else $error("enable-high hold exceeds enable time width");

endmodule

bind char_lcd_4bit_sequencer_unit lcd4_checker u_lcd4_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
